### rtl/core/dwn_pkg.sv
// ----------------------------------------------------------------------------
// dwn_pkg: shared constants
// Widths, formats and request codes of the distance weight normaliser.
// ----------------------------------------------------------------------------
`default_nettype none
package dwn_pkg;
  localparam int MaxStations = 8;
  localparam int CoordWidth  = 32;
  localparam int IdxW        = $clog2(MaxStations);
  localparam int CntW        = 4;
  // distance magnitude, squares, root and sums
  localparam int DiffW = CoordWidth + 1;
  localparam int SqW   = 2 * DiffW + 1;
  localparam int RootW = DiffW + 1;
  localparam int SumW  = RootW + IdxW;
  localparam int WSumW = 17 + IdxW;
  localparam int DivW  = (SumW > WSumW) ? SumW : WSumW;
  localparam logic [16:0] OneQ16 = 17'h10000;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_NODE = 1'b1;
  localparam logic CFG_COUNT = 1'b0;
  localparam logic CFG_THRESH = 1'b1;
endpackage
`default_nettype wire

### rtl/core/dwn_frac_div.sv
// ----------------------------------------------------------------------------
// dwn_frac_div: iterative Q1.16 fraction divider
// Computes min(floor(n*65536/d), 65536) for n <= d, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module dwn_frac_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [dwn_pkg::DivW-1:0] num,
  input  wire logic [dwn_pkg::DivW-1:0] den,
  output logic                         done,
  output logic [16:0]                  quot
);
  logic [dwn_pkg::DivW:0]   rem;
  logic [dwn_pkg::DivW-1:0] dreg;
  logic [16:0]              q;
  logic [4:0]               cnt;
  logic                     busy;
  logic [dwn_pkg::DivW:0]   shl;

  assign shl = {rem[dwn_pkg::DivW-1:0], 1'b0};

  // restoring step per cycle; integer part (0 or 1) seeds the quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        dreg <= den;
        if (num >= den) begin
          q   <= 17'd1;
          rem <= {1'b0, num - den};
        end else begin
          q   <= 17'd0;
          rem <= {1'b0, num};
        end
      end else if (busy) begin
        if (shl >= {1'b0, dreg}) begin
          rem <= shl - {1'b0, dreg};
          q   <= {q[15:0], 1'b1};
        end else begin
          rem <= shl;
          q   <= {q[15:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = (q > dwn_pkg::OneQ16) ? dwn_pkg::OneQ16 : q;
endmodule
`default_nettype wire

### rtl/core/dwn_isqrt.sv
// ----------------------------------------------------------------------------
// dwn_isqrt: iterative integer square root
// Floor root of a SqW-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module dwn_isqrt (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [dwn_pkg::SqW-1:0] val,
  output logic                         done,
  output logic [dwn_pkg::RootW-1:0]    root
);
  localparam int Steps = (dwn_pkg::SqW + 1) / 2;
  localparam int VW    = 2 * Steps;
  localparam int RemW  = Steps + 2;

  logic [VW-1:0]   v;
  logic [RemW-1:0] rem;
  logic [Steps-1:0] res;
  logic [$clog2(Steps+1)-1:0] cnt;
  logic busy;
  logic [RemW-1:0] rsh, trial;

  assign rsh   = {rem[RemW-3:0], v[VW-1:VW-2]};
  assign trial = {res[RemW-3:0], 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        v    <= VW'(val);
        rem  <= '0;
        res  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        v <= {v[VW-3:0], 2'b00};
        if (rsh >= trial) begin
          rem <= rsh - trial;
          res <= {res[Steps-2:0], 1'b1};
        end else begin
          rem <= rsh;
          res <= {res[Steps-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(Steps+1))'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = dwn_pkg::RootW'(res);
endmodule
`default_nettype wire

### rtl/core/distance_weight_normalizer_top.sv
// ----------------------------------------------------------------------------
// distance_weight_normalizer_top: inverse distance interpolation weights
// Station table, shared square root and fraction divider under a sequencer.
// ----------------------------------------------------------------------------
// A load request writes one station slot. A node request runs the shared
// bit-serial square root once per active station (34 steps, after the square
// set-up), then the shared divider for each raw weight (16 restoring steps)
// and for each normalised weight, which is then handed to the output register.
// The square root and divider loops set how long a node takes. A sum under
// the threshold skips its divisions, and a stalled output holds the sequencer.
// in_stall is high while a node is in work and while a result waits in the
// one-entry output register.
`default_nettype none
module distance_weight_normalizer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [2:0]  station_index,
  input  wire logic [dwn_pkg::CoordWidth-1:0] pos_x,
  input  wire logic [dwn_pkg::CoordWidth-1:0] pos_y,
  input  wire logic        node_batch_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       station_id,
  output logic [16:0]      weight,
  output logic             last_station,
  output logic             batch_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int IdxW = dwn_pkg::IdxW;
  localparam logic [2:0] ST_IDLE = 3'd0, ST_SQ = 3'd1, ST_SQW = 3'd2,
                         ST_RAW = 3'd3, ST_RAWW = 3'd4, ST_WT = 3'd5,
                         ST_WTW = 3'd6, ST_OUT = 3'd7;

  logic [2:0] state;
  logic [dwn_pkg::CntW-1:0] station_count;
  logic [15:0] small_threshold;
  logic signed [dwn_pkg::CoordWidth-1:0] tab_x [dwn_pkg::MaxStations];
  logic signed [dwn_pkg::CoordWidth-1:0] tab_y [dwn_pkg::MaxStations];
  logic [dwn_pkg::RootW-1:0] stn_dist [dwn_pkg::MaxStations];
  logic [16:0] raw [dwn_pkg::MaxStations];
  logic signed [dwn_pkg::CoordWidth-1:0] nx, ny;
  logic nbend;
  logic [IdxW-1:0] k, last_k;
  logic [dwn_pkg::SumW-1:0] s;
  logic [dwn_pkg::WSumW-1:0] t;
  logic raw_one, wt_one;

  // shared units
  logic sq_start, sq_done, dv_start, dv_done;
  logic [dwn_pkg::SqW-1:0] sq_val;
  logic [dwn_pkg::RootW-1:0] sq_root;
  logic [dwn_pkg::DivW-1:0] dv_num, dv_den;
  logic [16:0] dv_q;
  logic [dwn_pkg::DiffW-1:0] dx, dy;
  logic signed [dwn_pkg::DiffW-1:0] ddx, ddy;

  assign ddx = dwn_pkg::DiffW'(tab_x[k]) - dwn_pkg::DiffW'(nx);
  assign ddy = dwn_pkg::DiffW'(tab_y[k]) - dwn_pkg::DiffW'(ny);
  assign dx  = ddx[dwn_pkg::DiffW-1] ? dwn_pkg::DiffW'(-ddx) : dwn_pkg::DiffW'(ddx);
  assign dy  = ddy[dwn_pkg::DiffW-1] ? dwn_pkg::DiffW'(-ddy) : dwn_pkg::DiffW'(ddy);

  // squares registered before the root unit
  logic [dwn_pkg::SqW-1:0] sqx, sqy;
  always_ff @(posedge clk) begin
    sqx <= dwn_pkg::SqW'(dx * dx);
    sqy <= dwn_pkg::SqW'(dy * dy);
  end
  assign sq_val = sqx + sqy;

  dwn_isqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .val(sq_val),
                    .done(sq_done), .root(sq_root));
  dwn_frac_div u_div (.clk(clk), .rst(rst), .start(dv_start), .num(dv_num),
                      .den(dv_den), .done(dv_done), .quot(dv_q));

  assign in_stall  = (state != ST_IDLE) || out_valid;
  assign cfg_ready = (state == ST_IDLE) && !in_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      station_count   <= 4'd1;
      small_threshold <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == dwn_pkg::CFG_COUNT) station_count <= cfg_data[3:0];
      else small_threshold <= cfg_data;
    end
  end

  // load requests write the table
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && req_type == dwn_pkg::REQ_LOAD) begin
      tab_x[station_index[IdxW-1:0]] <= pos_x;
      tab_y[station_index[IdxW-1:0]] <= pos_y;
    end
  end

  logic sq_wait;
  always_comb begin
    dv_num = '0;
    dv_den = '0;
    if (state == ST_RAW) begin
      dv_num = dwn_pkg::DivW'(s - dwn_pkg::SumW'(stn_dist[k]));
      dv_den = dwn_pkg::DivW'(s);
    end else begin
      dv_num = dwn_pkg::DivW'(raw[k]);
      dv_den = dwn_pkg::DivW'(t);
    end
  end
  assign dv_start = (state == ST_RAW && !raw_one) || (state == ST_WT && !wt_one);
  assign sq_start = (state == ST_SQ) && sq_wait;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      sq_wait   <= 1'b0;
    end else begin
      // load the output register, or drop the request once taken
      if (state == ST_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall && req_type == dwn_pkg::REQ_NODE) begin
            nx <= pos_x;
            ny <= pos_y;
            nbend <= node_batch_end;
            k <= '0;
            s <= '0;
            sq_wait <= 1'b0;
            if (station_count == 4'd0) last_k <= '0;
            else if (station_count > 4'(dwn_pkg::MaxStations))
              last_k <= IdxW'(dwn_pkg::MaxStations - 1);
            else last_k <= IdxW'(station_count - 4'd1);
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          // wait for the squares to settle in their registers before the root starts
          if (!sq_wait) sq_wait <= 1'b1;
          else begin
            sq_wait <= 1'b0;
            state <= ST_SQW;
          end
        end
        ST_SQW: begin
          if (sq_done) begin
            stn_dist[k] <= sq_root;
            s <= s + dwn_pkg::SumW'(sq_root);
            if (k == last_k) begin
              k <= '0;
              t <= '0;
              state <= ST_RAW;
            end else begin
              k <= k + 1'b1;
              state <= ST_SQ;
            end
          end
        end
        ST_RAW: begin
          if (raw_one) begin
            raw[k] <= dwn_pkg::OneQ16;
            t <= t + dwn_pkg::WSumW'(dwn_pkg::OneQ16);
            if (k == last_k) begin
              k <= '0;
              state <= ST_WT;
            end else k <= k + 1'b1;
          end else state <= ST_RAWW;
        end
        ST_RAWW: begin
          if (dv_done) begin
            raw[k] <= dv_q;
            t <= t + dwn_pkg::WSumW'(dv_q);
            if (k == last_k) begin
              k <= '0;
              state <= ST_WT;
            end else begin
              k <= k + 1'b1;
              state <= ST_RAW;
            end
          end
        end
        ST_WT: begin
          if (!out_valid || !out_stall) begin
            if (wt_one) begin
              raw[k] <= dwn_pkg::OneQ16;
              state <= ST_OUT;
            end else state <= ST_WTW;
          end
        end
        ST_WTW: begin
          if (dv_done) begin
            raw[k] <= dv_q;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hand the weight to the output register once it is free
          if (!out_valid || !out_stall) begin
            station_id   <= 3'(k);
            weight       <= raw[k];
            last_station <= (k == last_k);
            batch_end    <= nbend;
            if (k == last_k) state <= ST_IDLE;
            else begin
              k <= k + 1'b1;
              state <= ST_WT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign raw_one = (s == '0) || (s < dwn_pkg::SumW'(small_threshold));
  assign wt_one  = (last_k == '0) || (t == '0) ||
                   (24'(t) < {small_threshold, 8'd0});

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(weight)))
    else $error("result dropped");
  a_wt_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weight <= dwn_pkg::OneQ16)) else $error("weight above one");
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && k == last_k && !(out_valid && out_stall)) |=>
    (state == ST_IDLE)) else $error("sequencer did not finish");
endmodule
`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for distance_weight_normalizer_top
// Loads the station table, sends node requests under random valid and stall
// gaps across several register settings, and compares every weight with an
// in-bench prediction of the distance sums and the two normalising divisions.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;

  localparam int CycleLimit = 2000000;
  localparam int HoldCycles = 3000;

  typedef struct {
    logic [2:0]  id;
    logic [16:0] w;
    logic        last;
    logic        bend;
  } weight_t;

  // Predicts weights per node request and holds them until they come out
  class weight_scoreboard;
    logic [31:0] pos_x_tab [dwn_pkg::MaxStations];
    logic [31:0] pos_y_tab [dwn_pkg::MaxStations];
    int unsigned active_count;
    int unsigned threshold;
    weight_t     due_weights [$];
    int          errors;

    function new();
      active_count = 1;
      threshold    = 1;
      errors       = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == dwn_pkg::CFG_COUNT) active_count = data[3:0];
      else                           threshold    = data;
    endfunction

    function logic [33:0] int_sqrt(logic [67:0] v);
      logic [69:0] rem_v;
      logic [69:0] trial;
      logic [35:0] root;
      rem_v = '0;
      root  = '0;
      for (int i = 33; i >= 0; i--) begin
        rem_v = (rem_v << 2) | v[2*i +: 2];
        trial = (70'(root) << 2) | 70'd1;
        if (rem_v >= trial) begin
          rem_v = rem_v - trial;
          root  = (root << 1) | 36'd1;
        end else begin
          root  = root << 1;
        end
      end
      return root[33:0];
    endfunction

    function longint unsigned distance(logic [31:0] ax, logic [31:0] ay,
                                       logic [31:0] bx, logic [31:0] by);
      longint dx, dy;
      logic [67:0] sq;
      dx = longint'($signed(ax)) - longint'($signed(bx));
      dy = longint'($signed(ay)) - longint'($signed(by));
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy);
      return int_sqrt(sq);
    endfunction

    function longint unsigned frac16(longint unsigned n, longint unsigned d);
      longint unsigned q;
      q = (n << 16) / d;
      return (q > 65536) ? 65536 : q;
    endfunction

    function void note_request(logic rt, logic [2:0] idx, logic [31:0] px,
                               logic [31:0] py, logic be);
      longint unsigned rdist [dwn_pkg::MaxStations];
      longint unsigned raw  [dwn_pkg::MaxStations];
      longint unsigned s, t, thr;
      int n;
      weight_t r;
      if (rt == dwn_pkg::REQ_LOAD) begin
        pos_x_tab[idx] = px;
        pos_y_tab[idx] = py;
        return;
      end
      n = active_count;
      if (n < 1) n = 1;
      if (n > dwn_pkg::MaxStations) n = dwn_pkg::MaxStations;
      thr = threshold;
      s = 0;
      t = 0;
      for (int k = 0; k < n; k++) begin
        rdist[k] = distance(pos_x_tab[k], pos_y_tab[k], px, py);
        s += rdist[k];
      end
      for (int k = 0; k < n; k++) begin
        raw[k] = (s == 0 || s < thr) ? 65536 : frac16(s - rdist[k], s);
        t += raw[k];
      end
      for (int k = 0; k < n; k++) begin
        r.id   = k[2:0];
        r.w    = (n == 1 || t == 0 || t < (thr << 8)) ? dwn_pkg::OneQ16 :
                 17'(frac16(raw[k], t));
        r.last = (k == n - 1);
        r.bend = be;
        due_weights.push_back(r);
      end
    endfunction

    function void check_result(logic [2:0] id, logic [16:0] w, logic last, logic bend);
      weight_t e;
      if (due_weights.size() == 0) begin
        $display("%0t: unexpected result id %0d weight %0d", $time, id, w);
        errors++;
        return;
      end
      e = due_weights.pop_front();
      if (id !== e.id) begin
        $display("%0t: station_id expected %0d got %0d", $time, e.id, id);
        errors++;
      end
      if (w !== e.w) begin
        $display("%0t: weight expected %0d got %0d (station %0d)", $time, e.w, w, e.id);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_station expected %0b got %0b", $time, e.last, last);
        errors++;
      end
      if (bend !== e.bend) begin
        $display("%0t: batch_end expected %0b got %0b", $time, e.bend, bend);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [2:0]  station_index;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic        node_batch_end;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  station_id;
  logic [16:0] weight;
  logic        last_station;
  logic        batch_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  weight_scoreboard weights_sb;
  bit  quiet;
  bit  hold_req;
  int  cycle_cnt;

  distance_weight_normalizer_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .station_index(station_index),
    .pos_x(pos_x), .pos_y(pos_y), .node_batch_end(node_batch_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .station_id(station_id), .weight(weight),
    .last_station(last_station), .batch_end(batch_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'h8000_0000 ^ 32'($urandom_range(0, 255));
      default: return 32'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // Offer one request and wait for it to be taken
  task automatic send_req(logic rt, logic [2:0] idx, logic [31:0] px,
                          logic [31:0] py, logic be);
    int g;
    in_valid       <= 1'b1;
    req_type       <= rt;
    station_index  <= idx;
    pos_x          <= px;
    pos_y          <= py;
    node_batch_end <= be;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    weights_sb.note_request(rt, idx, px, py, be);
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Lower valid and let everything due come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (weights_sb.due_weights.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    weights_sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(int n_req);
    for (int i = 0; i < n_req; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_req(dwn_pkg::REQ_LOAD, 3'($urandom_range(0, 7)), rand_coord(),
                 rand_coord(), 1'($urandom));
      else
        send_req(dwn_pkg::REQ_NODE, 3'($urandom), rand_coord(), rand_coord(),
                 1'($urandom));
    end
  endtask

  // Receiver stalls: random runs, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (1 + pick_gap()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      weights_sb.check_result(station_id, weight, last_station, batch_end);
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL distance_weight_normalizer_top");
      $finish;
    end
  end

  initial begin
    logic [3:0]  cnt_set [7];
    logic [15:0] thr_set [7];
    cnt_set = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd5};
    thr_set = '{16'd1, 16'd0, 16'd65535, 16'd1, 16'd300, 16'd2000, 16'd0};
    weights_sb = new();
    cycle_cnt  = 0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    req_type       <= dwn_pkg::REQ_LOAD;
    station_index  <= '0;
    pos_x          <= '0;
    pos_y          <= '0;
    node_batch_end <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= dwn_pkg::CFG_COUNT;
    cfg_data       <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every slot loaded before any node reads it; at reset one station is active
    send_req(dwn_pkg::REQ_LOAD, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_req(dwn_pkg::REQ_LOAD, 3'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_req(dwn_pkg::REQ_LOAD, 3'd2, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_req(dwn_pkg::REQ_LOAD, 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    for (int k = 4; k < 8; k++)
      send_req(dwn_pkg::REQ_LOAD, 3'(k), 32'(k * 256), 32'(-k * 512), 1'b0);
    send_req(dwn_pkg::REQ_NODE, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_req(dwn_pkg::REQ_NODE, 3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    drain();

    write_reg(dwn_pkg::CFG_COUNT, 16'd8);
    write_reg(dwn_pkg::CFG_THRESH, 16'd1);
    send_req(dwn_pkg::REQ_NODE, 3'd0, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_req(dwn_pkg::REQ_NODE, 3'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_req(dwn_pkg::REQ_NODE, 3'd0, 32'd0, 32'd0, 1'b0);
    send_req(dwn_pkg::REQ_NODE, 3'd0, 32'd1024, 32'hFFFF_F800, 1'b1);
    // All stations on one point, node on it: zero distance sum
    for (int k = 0; k < 8; k++)
      send_req(dwn_pkg::REQ_LOAD, 3'(k), 32'd4096, 32'hFFFF_F000, 1'b0);
    send_req(dwn_pkg::REQ_NODE, 3'd0, 32'd4096, 32'hFFFF_F000, 1'b1);
    send_req(dwn_pkg::REQ_NODE, 3'd0, 32'd4097, 32'hFFFF_F000, 1'b0);
    drain();

    // Random phases over several register settings
    for (int p = 0; p < 7; p++) begin
      write_reg(dwn_pkg::CFG_COUNT, 16'(cnt_set[p]));
      write_reg(dwn_pkg::CFG_THRESH, thr_set[p]);
      for (int k = 0; k < 8; k++)
        send_req(dwn_pkg::REQ_LOAD, 3'(k), rand_coord(), rand_coord(), 1'($urandom));
      quiet = (p == 2);
      if (p == 5) hold_req = 1'b1;
      send_random(p == 5 ? 50 : 35);
      drain();
    end
    quiet = 1'b0;

    if (weights_sb.due_weights.size() != 0) begin
      $display("%0t: %0d weights never arrived", $time, weights_sb.due_weights.size());
      weights_sb.errors++;
    end
    if (weights_sb.errors == 0) begin
      $display("PASS distance_weight_normalizer_top");
    end else begin
      $display("FAIL distance_weight_normalizer_top");
    end
    $finish;
  end

endmodule
